@@ src/polyphonic_voice_allocator_core_assert.svh @@
// Assertion macros shared by the voice allocator RTL.
`ifndef POLYPHONIC_VOICE_ALLOCATOR_CORE_ASSERT_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PVA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PVA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/pva_pkg.sv @@
// Package with types, codes and defaults of the polyphonic voice allocator.
package pva_pkg;

    localparam int VOICE_COUNT_DEF  = 32;
    localparam int MODULE_LIMIT_DEF = 64;

    localparam logic [7:0] CMD_MASK     = 8'hF0;
    localparam logic [7:0] CMD_NOTE_OFF = 8'h80;
    localparam logic [7:0] CMD_NOTE_ON  = 8'h90;
    localparam logic [7:0] CMD_PROGRAM  = 8'hC0;
    localparam logic [6:0] DEFAULT_VELOCITY = 7'd64;

    localparam logic [1:0] MODE_MIDI   = 2'd0;
    localparam logic [1:0] MODE_DIRECT = 2'd1;
    localparam logic [1:0] MODE_FREED  = 2'd2;

    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_START     = 3'd1;
    localparam logic [2:0] ACT_RETRIGGER = 3'd2;
    localparam logic [2:0] ACT_RELEASE   = 3'd3;
    localparam logic [2:0] ACT_DROPPED   = 3'd4;
    localparam logic [2:0] ACT_PROGRAM   = 3'd5;
    localparam logic [2:0] ACT_FREED     = 3'd6;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] arg_count;
        logic [7:0] status_byte;
        logic [6:0] data_one;
        logic [6:0] data_two;
        logic [4:0] finished_voice;
    } pva_in_t;

    typedef struct packed {
        logic [2:0] action;
        logic [4:0] voice_index;
        logic [6:0] voice_note;
        logic [6:0] voice_velocity;
        logic [5:0] module_index;
    } pva_out_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ON,
        OP_OFF,
        OP_PROG,
        OP_FREE
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_DIV,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic div_start;
        logic div_step;
        logic fetch;
        logic emit;
    } pva_cmd_t;

    typedef struct packed {
        op_t  op;
        logic scan_done;
        logic div_done;
        logic out_free;
    } pva_stat_t;

endpackage

@@ src/pva_ctrl.sv @@
// Controller state machine that sequences decode, voice scan, modulo and result.
module pva_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pva_pkg::pva_stat_t  stat,
    output pva_pkg::pva_cmd_t   cmd
);
    import pva_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (stat.op)
                    OP_ON, OP_OFF: state_next = ST_SCAN;
                    OP_PROG:       state_next = ST_DIV;
                    default:       state_next = ST_RESULT;
                endcase
            end
            ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_DECODE: begin
                cmd.scan_start = (stat.op == OP_ON) || (stat.op == OP_OFF);
                cmd.div_start  = (stat.op == OP_PROG);
                cmd.fetch      = (stat.op == OP_FREE);
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_RESULT: begin
                cmd.emit = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ src/pva_datapath.sv @@
// Datapath with the voice table, scan pipeline, modulo unit and output register.
module pva_datapath #(
    parameter int VOICE_COUNT  = pva_pkg::VOICE_COUNT_DEF,
    parameter int MODULE_LIMIT = pva_pkg::MODULE_LIMIT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [6:0]          cfg_wdata,
    input  pva_pkg::pva_in_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pva_pkg::pva_out_t   m_data,
    input  pva_pkg::pva_cmd_t   cmd,
    output pva_pkg::pva_stat_t  stat
);
    import pva_pkg::*;

    localparam int IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam logic [IW:0]   V_CNT    = (IW + 1)'(VOICE_COUNT);
    localparam logic [IW-1:0] LAST_IDX = IW'(VOICE_COUNT - 1);
    localparam int CLAMP = (MODULE_LIMIT < 127) ? MODULE_LIMIT : 127;
    localparam logic [6:0] CLAMP_N = 7'(CLAMP);

    typedef struct packed {
        logic [5:0] module_sel;
        logic [6:0] note;
    } voice_word_t;

    voice_word_t voice_mem [VOICE_COUNT];

    pva_in_t               item_reg;
    logic [6:0]            count_reg;
    logic [5:0]            sel_mod_reg;
    logic [VOICE_COUNT-1:0] active_reg;
    logic [VOICE_COUNT-1:0] releasing_reg;
    logic [VOICE_COUNT-1:0] active_next;
    logic [VOICE_COUNT-1:0] releasing_next;

    logic [IW:0]   rd_cnt_reg;
    logic          cmp_vld_reg;
    logic [IW-1:0] cmp_idx_reg;
    logic          done_reg;
    logic          found_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [5:0]    hit_mod_reg;
    logic          free_found_reg;
    logic [IW-1:0] free_idx_reg;
    voice_word_t   rd_data_reg;

    logic [6:0] rem_reg;
    logic [2:0] div_bit_reg;
    logic       div_done_reg;
    logic [7:0] rem_shift;

    logic       m_valid_reg;
    pva_out_t   m_data_reg;
    pva_out_t   res;

    logic [6:0]    n_mod;
    logic [7:0]    cmd_nib;
    logic          is_note;
    logic [6:0]    note_vel;
    op_t           op;
    logic [IW-1:0] fin_idx;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          scan_rd;
    logic          hit;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    voice_word_t   wr_data;
    logic [IW-1:0] slot;

    assign n_mod   = (count_reg > CLAMP_N) ? CLAMP_N : count_reg;
    assign cmd_nib = item_reg.status_byte & CMD_MASK;
    assign fin_idx = IW'(item_reg.finished_voice);

    always_comb begin
        op       = OP_NONE;
        is_note  = 1'b0;
        note_vel = item_reg.data_two;
        unique case (item_reg.mode)
            MODE_MIDI: begin
                priority if (!item_reg.arg_count[1]) begin
                    op = OP_NONE;
                end else if (cmd_nib == CMD_NOTE_OFF) begin
                    is_note  = 1'b1;
                    note_vel = '0;
                end else if (cmd_nib == CMD_NOTE_ON) begin
                    is_note  = 1'b1;
                    note_vel = (item_reg.arg_count == 2'd3) ? item_reg.data_two
                                                            : DEFAULT_VELOCITY;
                end else if (cmd_nib == CMD_PROGRAM) begin
                    op = (n_mod != '0) ? OP_PROG : OP_NONE;
                end else begin
                    op = OP_NONE;
                end
            end
            MODE_DIRECT: begin
                is_note = item_reg.arg_count[1];
            end
            MODE_FREED: begin
                if (32'(item_reg.finished_voice) < VOICE_COUNT) begin
                    op = OP_FREE;
                end
            end
            default: op = OP_NONE;
        endcase
        if (is_note && (n_mod != '0)) begin
            op = (note_vel != '0) ? OP_ON : OP_OFF;
        end
    end

    assign scan_rd = cmd.scan_step && (rd_cnt_reg < V_CNT);
    assign rd_en   = scan_rd || cmd.fetch;
    assign rd_addr = cmd.fetch ? fin_idx : rd_cnt_reg[IW-1:0];

    assign hit = cmd.scan_step && cmp_vld_reg && !done_reg && active_reg[cmp_idx_reg]
                 && (rd_data_reg.note == item_reg.data_one)
                 && ((op == OP_ON) || !releasing_reg[cmp_idx_reg]);

    assign rem_shift = {rem_reg, item_reg.data_one[div_bit_reg]};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (rd_en) begin
            rd_data_reg <= voice_mem[rd_addr];
        end
        if (wr_en) begin
            voice_mem[wr_addr] <= wr_data;
        end
        if (cmd.scan_start) begin
            rd_cnt_reg <= '0;
        end else if (scan_rd) begin
            rd_cnt_reg <= rd_cnt_reg + 1'b1;
        end
        if (scan_rd) begin
            cmp_idx_reg <= rd_cnt_reg[IW-1:0];
        end
        if (hit) begin
            hit_idx_reg <= cmp_idx_reg;
            hit_mod_reg <= rd_data_reg.module_sel;
        end
        if (cmd.scan_step && cmp_vld_reg && !done_reg && !free_found_reg
            && !active_reg[cmp_idx_reg]) begin
            free_idx_reg <= cmp_idx_reg;
        end
        if (cmd.div_start) begin
            rem_reg     <= '0;
            div_bit_reg <= 3'd6;
        end else if (cmd.div_step && !div_done_reg) begin
            rem_reg     <= (rem_shift >= {1'b0, n_mod}) ? 7'(rem_shift - {1'b0, n_mod})
                                                         : rem_shift[6:0];
            div_bit_reg <= div_bit_reg - 1'b1;
        end
        if (cmd.emit) begin
            m_data_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            sel_mod_reg    <= '0;
            active_reg     <= '0;
            releasing_reg  <= '0;
            cmp_vld_reg    <= 1'b0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            div_done_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                count_reg <= cfg_wdata;
            end
            if (cmd.emit && (op == OP_PROG)) begin
                sel_mod_reg <= rem_reg[5:0];
            end
            active_reg    <= active_next;
            releasing_reg <= releasing_next;
            if (cmd.scan_start) begin
                cmp_vld_reg    <= 1'b0;
                done_reg       <= 1'b0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end else if (cmd.scan_step) begin
                cmp_vld_reg <= scan_rd;
                if (hit) begin
                    found_reg <= 1'b1;
                end
                if (cmp_vld_reg && !done_reg && !active_reg[cmp_idx_reg]) begin
                    free_found_reg <= 1'b1;
                end
                if (hit || (cmp_vld_reg && (cmp_idx_reg == LAST_IDX))) begin
                    done_reg <= 1'b1;
                end
            end
            if (cmd.div_start) begin
                div_done_reg <= 1'b0;
            end else if (cmd.div_step && (div_bit_reg == '0)) begin
                div_done_reg <= 1'b1;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign slot = found_reg ? hit_idx_reg : free_idx_reg;

    always_comb begin
        res            = '0;
        wr_en          = 1'b0;
        wr_addr        = slot;
        wr_data        = '{module_sel: sel_mod_reg, note: item_reg.data_one};
        active_next    = active_reg;
        releasing_next = releasing_reg;
        unique case (op)
            OP_ON: begin
                res.voice_note     = item_reg.data_one;
                res.voice_velocity = note_vel;
                res.module_index   = sel_mod_reg;
                if (found_reg || free_found_reg) begin
                    res.action      = found_reg ? ACT_RETRIGGER : ACT_START;
                    res.voice_index = 5'(slot);
                    wr_en           = cmd.emit;
                    if (cmd.emit) begin
                        active_next[slot]    = 1'b1;
                        releasing_next[slot] = 1'b0;
                    end
                end else begin
                    res.action = ACT_DROPPED;
                end
            end
            OP_OFF: begin
                if (found_reg) begin
                    res.action       = ACT_RELEASE;
                    res.voice_index  = 5'(hit_idx_reg);
                    res.voice_note   = item_reg.data_one;
                    res.module_index = hit_mod_reg;
                    if (cmd.emit) begin
                        releasing_next[hit_idx_reg] = 1'b1;
                    end
                end
            end
            OP_PROG: begin
                res.action       = ACT_PROGRAM;
                res.module_index = rem_reg[5:0];
            end
            OP_FREE: begin
                if (active_reg[fin_idx]) begin
                    res.action       = ACT_FREED;
                    res.voice_index  = item_reg.finished_voice;
                    res.voice_note   = rd_data_reg.note;
                    res.module_index = rd_data_reg.module_sel;
                    if (cmd.emit) begin
                        active_next[fin_idx]    = 1'b0;
                        releasing_next[fin_idx] = 1'b0;
                    end
                end
            end
            default: begin
                res = '0;
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_data         = m_data_reg;
    assign stat.op        = op;
    assign stat.scan_done = done_reg;
    assign stat.div_done  = div_done_reg;
    assign stat.out_free  = !m_valid_reg || m_ready;

endmodule

@@ src/polyphonic_voice_allocator_core.sv @@
// Top level of the polyphonic voice allocator: controller, datapath and checks.
// The input channel (s_valid, s_ready, s_data) takes one event per beat: a MIDI
// message, a direct note/velocity list or a voice-finished notice. The result
// channel (m_valid, m_ready, m_data) gives exactly one beat for every input beat.
// The number of sound modules is written through cfg_we and cfg_wdata; the user
// must write it only while the block is idle; the block does not enforce it.
// One event is worked on at a time. A note-on or note-off scans the voice table
// one voice per cycle through the single read port of the voice memory, and a
// matching voice ends the scan early. A program change runs a bit-serial modulo
// over the seven bits of the program number. A voice-finished notice or an
// ignored event goes from decode straight to the result. s_ready returns in the
// cycle after the result is loaded.
// The result sits in an output register. When the receiver stalls, s_ready
// returns once the result has been loaded, so the next event is taken while
// the last result still waits; that event finishes only when the register
// frees up.
// Reset clears all voice flags, the module count and the selected program and
// drops any pending result.
`include "polyphonic_voice_allocator_core_assert.svh"

module polyphonic_voice_allocator_core #(
    parameter int VOICE_COUNT  = pva_pkg::VOICE_COUNT_DEF,
    parameter int MODULE_LIMIT = pva_pkg::MODULE_LIMIT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [6:0]        cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  pva_pkg::pva_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pva_pkg::pva_out_t m_data
);
    import pva_pkg::*;

    pva_cmd_t  cmd;
    pva_stat_t stat;

    pva_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pva_datapath #(
        .VOICE_COUNT  (VOICE_COUNT),
        .MODULE_LIMIT (MODULE_LIMIT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    `PVA_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready,
        "A second beat was accepted while an event was still in work.")
    `PVA_ASSERT_IMP(a_emit_room, cmd.emit, stat.out_free,
        "A result was loaded over a beat that had not been taken.")
    `PVA_ASSERT_NEXT(a_emit_shows, cmd.emit, m_valid,
        "A loaded result did not show on the result channel.")
    `PVA_ASSERT_IMP(a_none_zero, m_valid && (m_data.action == ACT_NONE),
        (m_data.voice_index == '0) && (m_data.voice_note == '0)
        && (m_data.voice_velocity == '0) && (m_data.module_index == '0),
        "A result with no action carried nonzero fields.")

endmodule

@@ tb/sv/tb_polyphonic_voice_allocator_core.sv @@
// Self-checking testbench for the polyphonic voice allocator core.
`timescale 1ns / 1ps

module tb_polyphonic_voice_allocator_core;
    import pva_pkg::*;

    localparam int NVOICE = VOICE_COUNT_DEF;
    localparam int MODULE_CAP = MODULE_LIMIT_DEF;
    localparam logic [1:0] MODE_RESERVED = 2'd3;
    localparam int LONG_HOLD_CYCLES = 400;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [6:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    pva_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    pva_out_t m_data;

    polyphonic_voice_allocator_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Mirror of the voice table and settings inside the block.
    bit voice_on [NVOICE];
    bit voice_releasing [NVOICE];
    logic [6:0] voice_note_tbl [NVOICE];
    logic [6:0] voice_vel_tbl [NVOICE];
    logic [5:0] voice_mod_tbl [NVOICE];
    logic [5:0] program_sel = '0;
    logic [6:0] module_count_cfg = '0;

    pva_in_t pending_events [$];
    pva_out_t expected_actions [$];
    pva_out_t next_expected;
    int mismatch_count = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    bit idle_en = 1'b1;
    int hold_left = 0;
    int holds_requested = 0;
    int holds_served = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(5_000_000);
        $display("TB_ERROR");
        $finish;
    end

    function automatic int modules_in_use();
        return (module_count_cfg > MODULE_CAP) ? MODULE_CAP : int'(module_count_cfg);
    endfunction

    function automatic pva_out_t note_result(logic [6:0] note, logic [6:0] vel);
        pva_out_t r;
        int slot;
        int i;
        r = '0;
        slot = -1;
        if (modules_in_use() == 0)
            return r;
        if (vel != 0) begin
            for (i = 0; i < NVOICE && slot < 0; i++)
                if (voice_on[i] && voice_note_tbl[i] == note)
                    slot = i;
            if (slot >= 0) begin
                r.action = ACT_RETRIGGER;
            end else begin
                for (i = 0; i < NVOICE && slot < 0; i++)
                    if (!voice_on[i])
                        slot = i;
                r.action = ACT_START;
            end
            r.voice_note = note;
            r.voice_velocity = vel;
            r.module_index = program_sel;
            if (slot < 0) begin
                r.action = ACT_DROPPED;
                return r;
            end
            voice_note_tbl[slot] = note;
            voice_vel_tbl[slot] = vel;
            voice_mod_tbl[slot] = program_sel;
            voice_releasing[slot] = 1'b0;
            voice_on[slot] = 1'b1;
            r.voice_index = 5'(slot);
            return r;
        end
        for (i = 0; i < NVOICE; i++) begin
            if (voice_on[i] && voice_note_tbl[i] == note && !voice_releasing[i]) begin
                voice_releasing[i] = 1'b1;
                r.action = ACT_RELEASE;
                r.voice_index = 5'(i);
                r.voice_note = note;
                r.module_index = voice_mod_tbl[i];
                return r;
            end
        end
        return r;
    endfunction

    function automatic pva_out_t predict_action(pva_in_t ev);
        pva_out_t r;
        logic [7:0] cmd;
        r = '0;
        cmd = ev.status_byte & CMD_MASK;
        case (ev.mode)
            MODE_MIDI: begin
                if (ev.arg_count >= 2) begin
                    if (cmd == CMD_NOTE_OFF) begin
                        r = note_result(ev.data_one, 7'd0);
                    end else if (cmd == CMD_NOTE_ON) begin
                        r = note_result(ev.data_one,
                                        (ev.arg_count == 2'd3) ? ev.data_two : DEFAULT_VELOCITY);
                    end else if (cmd == CMD_PROGRAM && modules_in_use() != 0) begin
                        program_sel = 6'(int'(ev.data_one) % modules_in_use());
                        r.action = ACT_PROGRAM;
                        r.module_index = program_sel;
                    end
                end
            end
            MODE_DIRECT: begin
                if (ev.arg_count >= 2)
                    r = note_result(ev.data_one, ev.data_two);
            end
            MODE_FREED: begin
                if (voice_on[ev.finished_voice]) begin
                    voice_on[ev.finished_voice] = 1'b0;
                    voice_releasing[ev.finished_voice] = 1'b0;
                    r.action = ACT_FREED;
                    r.voice_index = ev.finished_voice;
                    r.voice_note = voice_note_tbl[ev.finished_voice];
                    r.module_index = voice_mod_tbl[ev.finished_voice];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic pva_in_t midi_msg(logic [7:0] status, logic [1:0] argc,
                                         logic [6:0] d1, logic [6:0] d2);
        pva_in_t m;
        m.mode = MODE_MIDI;
        m.arg_count = argc;
        m.status_byte = status;
        m.data_one = d1;
        m.data_two = d2;
        m.finished_voice = 5'($urandom);
        return m;
    endfunction

    function automatic pva_in_t direct_msg(logic [1:0] argc, logic [6:0] d1, logic [6:0] d2);
        pva_in_t m;
        m = midi_msg(8'($urandom), argc, d1, d2);
        m.mode = MODE_DIRECT;
        return m;
    endfunction

    function automatic pva_in_t finish_msg(logic [4:0] voice);
        pva_in_t m;
        m = midi_msg(8'($urandom), 2'($urandom), 7'($urandom), 7'($urandom));
        m.mode = MODE_FREED;
        m.finished_voice = voice;
        return m;
    endfunction

    function automatic pva_in_t random_msg();
        int pick;
        logic [6:0] note;
        logic [6:0] vel;
        logic [1:0] argc;
        logic [7:0] chan;
        pick = $urandom_range(0, 99);
        note = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'(48 + $urandom_range(0, 39));
        vel = ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
        argc = ($urandom_range(0, 5) == 0) ? 2'd2 : 2'd3;
        chan = 8'($urandom_range(0, 15));
        if (pick < 30)
            return midi_msg(CMD_NOTE_ON | chan, argc, note, vel);
        if (pick < 45)
            return midi_msg(CMD_NOTE_OFF | chan, argc, note, 7'($urandom));
        if (pick < 60)
            return direct_msg(argc, note, vel);
        if (pick < 78)
            return finish_msg(5'($urandom));
        if (pick < 85)
            return midi_msg(CMD_PROGRAM | chan, argc, 7'($urandom), 7'($urandom));
        return pva_in_t'(31'($urandom));
    endfunction

    function automatic int pick_gap();
        int pick;
        if (!idle_en)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic check_field(input string label, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_events.size() != 0 || s_valid || expected_actions.size() != 0);
    endtask

    task automatic write_module_count(input logic [6:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        module_count_cfg = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Distinct notes past the table size, so the last ones must be dropped.
    task automatic push_note_burst();
        int base;
        base = $urandom_range(0, 94);
        for (int k = 0; k < NVOICE + 2; k++) begin
            if (k % 2 == 0)
                pending_events.push_back(midi_msg(CMD_NOTE_ON | 8'($urandom_range(0, 15)),
                                                  2'd3, 7'(base + k), 7'($urandom_range(1, 127))));
            else
                pending_events.push_back(direct_msg(2'd2, 7'(base + k),
                                                    7'($urandom_range(1, 127))));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_actions.push_back(predict_action(s_data));
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_events.size() != 0) begin
                    s_data <= pending_events.pop_front();
                    s_valid <= 1'b1;
                    tx_gap <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            holds_served <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_requested) begin
            hold_left <= LONG_HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_actions.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result beat, expected none, actual %p",
                             $time, m_data);
                end else begin
                    next_expected = expected_actions.pop_front();
                    check_field("action", next_expected.action, m_data.action);
                    check_field("voice_index", next_expected.voice_index, m_data.voice_index);
                    check_field("voice_note", next_expected.voice_note, m_data.voice_note);
                    check_field("voice_velocity", next_expected.voice_velocity,
                                m_data.voice_velocity);
                    check_field("module_index", next_expected.module_index,
                                m_data.module_index);
                end
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                rx_gap <= pick_gap();
            end
        end
    end

    initial begin
        logic [6:0] count_plan [8];
        pva_in_t odd_msg;
        count_plan = '{7'd1, 7'd64, 7'd37, 7'd0, 7'd127, 7'd5, 7'd65, 7'd2};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // With no modules, notes and program changes are ignored.
        pending_events.push_back(midi_msg(CMD_NOTE_ON, 2'd3, 7'd60, 7'd100));
        pending_events.push_back(midi_msg(CMD_PROGRAM, 2'd2, 7'd3, 7'd0));
        pending_events.push_back(finish_msg(5'd0));
        wait_idle();

        write_module_count(7'd127);
        pending_events.push_back(midi_msg(CMD_PROGRAM, 2'd2, 7'd127, 7'd0));
        pending_events.push_back(midi_msg(CMD_PROGRAM | 8'h05, 2'd3, 7'd0, 7'd127));
        pending_events.push_back(midi_msg(CMD_NOTE_ON, 2'd3, 7'd0, 7'd127));
        pending_events.push_back(midi_msg(CMD_NOTE_ON | 8'h0F, 2'd2, 7'd127, 7'd0));
        pending_events.push_back(midi_msg(CMD_NOTE_ON, 2'd3, 7'd0, 7'd1));
        pending_events.push_back(midi_msg(CMD_NOTE_ON | 8'h03, 2'd3, 7'd0, 7'd0));
        pending_events.push_back(midi_msg(CMD_NOTE_OFF, 2'd2, 7'd0, 7'd0));
        pending_events.push_back(midi_msg(CMD_NOTE_OFF | 8'h0F, 2'd3, 7'd127, 7'd127));
        pending_events.push_back(direct_msg(2'd2, 7'd5, 7'd0));
        pending_events.push_back(direct_msg(2'd3, 7'd5, 7'd9));
        pending_events.push_back(direct_msg(2'd1, 7'd6, 7'd9));
        pending_events.push_back(midi_msg(CMD_NOTE_ON, 2'd0, 7'd7, 7'd9));
        pending_events.push_back(midi_msg(CMD_NOTE_ON | 8'h0F, 2'd1, 7'd7, 7'd9));
        pending_events.push_back(midi_msg(8'hB0, 2'd3, 7'd7, 7'd9));
        odd_msg = direct_msg(2'd3, 7'd9, 7'd9);
        odd_msg.mode = MODE_RESERVED;
        pending_events.push_back(odd_msg);
        pending_events.push_back(finish_msg(5'd0));
        pending_events.push_back(finish_msg(5'd0));
        pending_events.push_back(finish_msg(5'd31));
        pending_events.push_back(midi_msg(CMD_PROGRAM, 2'd2, 7'd100, 7'd0));
        pending_events.push_back(midi_msg(CMD_NOTE_ON, 2'd3, 7'd64, 7'd64));
        wait_idle();

        foreach (count_plan[p]) begin
            write_module_count(count_plan[p]);
            idle_en = (p % 3 != 1);
            if (p == 1)
                holds_requested++;
            if (p == 1 || p == 4)
                push_note_burst();
            repeat (45) pending_events.push_back(random_msg());
            wait_idle();
        end

        idle_en = 1'b1;
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0 && expected_actions.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/pva_pkg.sv
src/pva_ctrl.sv
src/pva_datapath.sv
src/polyphonic_voice_allocator_core.sv
tb/sv/tb_polyphonic_voice_allocator_core.sv
